/* rtl/lja_pkg.sv */
// Shared types and constants for the Lennard-Jones energy accumulator.
package lja_pkg;

  localparam int unsigned MAX_PARTICLES_DEF = 65536;
  localparam int unsigned POS_W = 32;
  localparam int unsigned IDX_W = 16;
  localparam int unsigned BOX_W = 31;
  localparam int unsigned ACC_W = 64;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned IN_TDATA_W = 112;
  localparam int unsigned CNT_W = 7;
  localparam logic [BOX_W-1:0] BOX_RESET = 31'd65536;

  localparam logic [CFG_IDX_W-1:0] REG_REF_X = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REF_Y = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REF_Z = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REF_INDEX = 8'd3;
  localparam logic [CFG_IDX_W-1:0] REG_START_INDEX = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_X = 8'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_Y = 8'd6;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_Z = 8'd7;

  // multiplier operations, in issue order
  localparam logic [2:0] MOP_SQ_X = 3'd0;
  localparam logic [2:0] MOP_SQ_Y = 3'd1;
  localparam logic [2:0] MOP_SQ_Z = 3'd2;
  localparam logic [2:0] MOP_R4 = 3'd3;
  localparam logic [2:0] MOP_R6 = 3'd4;
  localparam logic [2:0] MOP_R12 = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AXIS,
    ST_MUL,
    ST_MDONE,
    ST_CHK,
    ST_DIV,
    ST_ENERGY,
    ST_FIN
  } state_t;

endpackage

/* rtl/lennard_jones_energy_accumulator.sv */
// Top level: Lennard-Jones pair energy accumulator with minimum-image distance.
//
// One partner is taken at a time. An eligible partner goes through the minimum image
// for each axis in turn, three bit-serial squares, a restoring division for r^-2
// and three bit-serial products for r^-4, r^-6 and r^-12, all on one shift-add
// multiplier that retires one bit per cycle. A skipped partner goes from the
// minimum-image steps straight to the finish state. The sum and saturation flag
// are presented on the partner marked tlast and held in an output register,
// so the next partner is taken while the result waits.
module lennard_jones_energy_accumulator
  import lja_pkg::*;
#(
  parameter int unsigned MAX_PARTICLES = MAX_PARTICLES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [POS_W-1:0]      cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // pos_x[31:0], pos_y[63:32], pos_z[95:64], partner_index[111:96]
  input  logic [IN_TDATA_W-1:0] s_tdata,
  input  logic                  s_tlast,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // energy_sum[63:0]
  output logic [ACC_W-1:0]      m_tdata,
  // saturated[0]
  output logic                  m_tuser
);

  localparam logic [IDX_W:0] MAX_P = (IDX_W+1)'(MAX_PARTICLES);

  state_t state, state_next;

  logic signed [POS_W-1:0] ref_x, ref_y, ref_z;
  logic [IDX_W-1:0] ref_index, start_index;
  logic [BOX_W-1:0] box_x, box_y, box_z;

  logic signed [POS_W-1:0] px, py, pz;
  logic [IDX_W-1:0] pidx;
  logic plast;

  logic signed [ACC_W-1:0] acc;
  logic sat;
  logic [CNT_W-1:0] cnt;
  logic [2:0] mop;
  logic far;
  logic [30:0] av [3];
  logic [63:0] ssum, ma, mb, rem, quo, xr, yr;
  logic [127:0] mp;

  // minimum image for the current axis
  logic [1:0] k;
  logic signed [POS_W-1:0] sp, sr;
  logic [BOX_W-1:0] sl;
  logic signed [34:0] d, d2, ln, dm, da;
  logic far_k;

  assign k = cnt[1:0];

  always_comb begin
    unique case (k)
      2'd0: begin sp = px; sr = ref_x; sl = box_x; end
      2'd1: begin sp = py; sr = ref_y; sl = box_y; end
      default: begin sp = pz; sr = ref_z; sl = box_z; end
    endcase
    d = 35'(sp) - 35'(sr);
    d2 = d <<< 1;
    ln = $signed({4'd0, sl});
    if (d2 > ln) begin
      dm = d - ln;
    end else if (d2 <= -ln) begin
      dm = d + ln;
    end else begin
      dm = d;
    end
    da = dm[34] ? -dm : dm;
    far_k = (da[34:31] != 4'd0);
  end

  logic eligible;
  assign eligible = (pidx >= start_index) && (pidx != ref_index) && ({1'b0, pidx} < MAX_P);

  // serial multiplier and divider step
  logic [64:0] mup;
  logic [64:0] trial;
  logic [63:0] rnd;
  assign mup = {1'b0, mp[127:64]} + (mb[0] ? {1'b0, ma} : 65'd0);
  assign trial = {rem, (cnt == '0)};
  assign rnd = mp[95:32] + {63'd0, mp[31]};

  // energy update
  logic signed [65:0] ds;
  logic signed [67:0] esum;
  logic too_big;
  assign ds = $signed({2'b00, yr}) - $signed({2'b00, xr});
  assign esum = 68'(acc) + (68'(ds) <<< 2);
  assign too_big = !ds[65] && (ds[63:61] != 3'd0);

  assign cfg_ready = 1'b1;
  assign s_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_AXIS;
      end
      ST_AXIS: begin
        if (!eligible) state_next = ST_FIN;
        else if (k == 2'd2) state_next = (far || far_k) ? ST_FIN : ST_MUL;
      end
      ST_MUL: begin
        if (cnt == CNT_W'(63)) state_next = ST_MDONE;
      end
      ST_MDONE: begin
        if (mop == MOP_SQ_Z) state_next = ST_CHK;
        else if (mop == MOP_R12) state_next = ST_ENERGY;
        else state_next = ST_MUL;
      end
      ST_CHK: begin
        state_next = (ssum[63:27] == 37'd0) ? ST_FIN : ST_DIV;
      end
      ST_DIV: begin
        if (cnt == CNT_W'(64)) state_next = ST_MUL;
      end
      ST_ENERGY: state_next = ST_FIN;
      ST_FIN: begin
        if (!plast || !m_tvalid || m_tready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_x <= '0;
      ref_y <= '0;
      ref_z <= '0;
      ref_index <= '0;
      start_index <= '0;
      box_x <= BOX_RESET;
      box_y <= BOX_RESET;
      box_z <= BOX_RESET;
      acc <= '0;
      sat <= 1'b0;
      m_tvalid <= 1'b0;
      cnt <= '0;
      mop <= MOP_SQ_X;
      far <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_REF_X: ref_x <= cfg_data;
          REG_REF_Y: ref_y <= cfg_data;
          REG_REF_Z: ref_z <= cfg_data;
          REG_REF_INDEX: ref_index <= cfg_data[IDX_W-1:0];
          REG_START_INDEX: start_index <= cfg_data[IDX_W-1:0];
          REG_BOX_X: box_x <= cfg_data[BOX_W-1:0];
          REG_BOX_Y: box_y <= cfg_data[BOX_W-1:0];
          REG_BOX_Z: box_z <= cfg_data[BOX_W-1:0];
          default: ;
        endcase
      end
      if (state == ST_FIN && plast && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          cnt <= '0;
          far <= 1'b0;
          ssum <= '0;
          if (s_tvalid) begin
            px <= s_tdata[31:0];
            py <= s_tdata[63:32];
            pz <= s_tdata[95:64];
            pidx <= s_tdata[111:96];
            plast <= s_tlast;
          end
        end
        ST_AXIS: begin
          av[k] <= da[30:0];
          far <= far || far_k;
          if (k == 2'd2) begin
            cnt <= '0;
            mop <= MOP_SQ_X;
            ma <= {33'd0, av[0]};
            mb <= {33'd0, av[0]};
            mp <= '0;
          end else begin
            cnt <= cnt + CNT_W'(1);
          end
        end
        ST_MUL: begin
          mp <= {mup, mp[63:1]};
          mb <= mb >> 1;
          cnt <= cnt + CNT_W'(1);
        end
        ST_MDONE: begin
          cnt <= '0;
          mp <= '0;
          mop <= mop + 3'd1;
          case (mop)
            MOP_SQ_X: begin
              ssum <= ssum + mp[63:0];
              ma <= {33'd0, av[1]};
              mb <= {33'd0, av[1]};
            end
            MOP_SQ_Y: begin
              ssum <= ssum + mp[63:0];
              ma <= {33'd0, av[2]};
              mb <= {33'd0, av[2]};
            end
            MOP_SQ_Z: ssum <= ssum + mp[63:0];
            MOP_R4: begin
              ma <= rnd;
              mb <= quo;
            end
            MOP_R6: begin
              xr <= rnd;
              ma <= rnd;
              mb <= rnd;
            end
            default: yr <= rnd;
          endcase
        end
        ST_CHK: begin
          cnt <= '0;
          rem <= '0;
          quo <= '0;
          if (ssum[63:27] == 37'd0) begin
            acc <= {1'b0, {(ACC_W-1){1'b1}}};
            sat <= 1'b1;
          end
        end
        ST_DIV: begin
          if (trial >= {1'b0, ssum}) begin
            rem <= 64'(trial - {1'b0, ssum});
            quo <= {quo[62:0], 1'b1};
          end else begin
            rem <= trial[63:0];
            quo <= {quo[62:0], 1'b0};
          end
          cnt <= (cnt == CNT_W'(64)) ? '0 : cnt + CNT_W'(1);
          if (cnt == CNT_W'(64)) begin
            if (trial >= {1'b0, ssum}) begin
              ma <= {quo[62:0], 1'b1};
              mb <= {quo[62:0], 1'b1};
            end else begin
              ma <= {quo[62:0], 1'b0};
              mb <= {quo[62:0], 1'b0};
            end
            mp <= '0;
          end
        end
        ST_ENERGY: begin
          if (too_big || (esum > 68'sh7FFF_FFFF_FFFF_FFFF)) begin
            acc <= {1'b0, {(ACC_W-1){1'b1}}};
            sat <= 1'b1;
          end else if (esum < -68'sh8000_0000_0000_0000) begin
            acc <= {1'b1, {(ACC_W-1){1'b0}}};
            sat <= 1'b1;
          end else begin
            acc <= esum[63:0];
          end
        end
        ST_FIN: begin
          if (plast && (!m_tvalid || m_tready)) begin
            m_tdata <= acc;
            m_tuser <= sat;
            acc <= '0;
            sat <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

/* rtl/lja_checker.sv */
// Port-level checks for the Lennard-Jones energy accumulator, bound to the top level.
module lja_checker
  import lja_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  s_tlast,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [ACC_W-1:0]      m_tdata,
  input logic                  m_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second transaction taken while busy");

  a_no_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !s_tlast |=> !$rose(m_tvalid))
    else $error("result without a last transaction");

  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind lennard_jones_energy_accumulator lja_checker u_lja_checker (
  .clk(clk),
  .rst(rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .s_tlast(s_tlast),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata(m_tdata),
  .m_tuser(m_tuser)
);
